### src/sca_pkg.sv
// Shared types, constants and size-class tables for the size-class block allocator.
`timescale 1ns / 1ps
package sca_pkg;

	// Field widths and fixed geometry
	localparam int ADDR_W          = 20;
	localparam int SIZE_W          = 13;
	localparam int CLASS_COUNT     = 16;
	localparam int CLASS_W         = 4;
	localparam int LINK_DEPTH      = 65536;
	localparam int LINK_IDX_W      = 16;
	localparam int BLOCK_LSB       = 4;
	localparam int LARGEST_BLOCK   = 4096;

	// Defaults for the top-level parameters
	localparam int DEF_CHUNK_BYTES = 16384;
	localparam int DEF_CHUNK_LIMIT = 64;

	// Request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_IGNORED   = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NO_CHUNK  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_POP_WAIT,
		S_CARVE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] granted_address;
		status_t           status;
	} resp_t;

	// One free-list link: valid flag over a pool byte address
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
	} link_t;

	localparam int LINK_W = $bits(link_t);

	// Block size of each class
	function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] cls);
		logic [SIZE_W-1:0] b;
		case (cls)
			4'd0:    b = 13'd16;
			4'd1:    b = 13'd32;
			4'd2:    b = 13'd64;
			4'd3:    b = 13'd96;
			4'd4:    b = 13'd128;
			4'd5:    b = 13'd160;
			4'd6:    b = 13'd192;
			4'd7:    b = 13'd224;
			4'd8:    b = 13'd256;
			4'd9:    b = 13'd320;
			4'd10:   b = 13'd384;
			4'd11:   b = 13'd448;
			4'd12:   b = 13'd512;
			4'd13:   b = 13'd1024;
			4'd14:   b = 13'd2048;
			default: b = 13'd4096;
		endcase
		return b;
	endfunction

	// Smallest class whose block holds the size; oversize lands in the last class
	function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
		logic [CLASS_W-1:0] c;
		c = CLASS_W'(CLASS_COUNT - 1);
		for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
			if (size <= class_bytes(CLASS_W'(i)))
				c = CLASS_W'(i);
		end
		return c;
	endfunction

endpackage

### src/sca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### src/sca_step_unit.sv
// Carve step: advance block address, count down chunk bytes, test for a next block.
`timescale 1ns / 1ps
module sca_step_unit #(
	parameter int REM_W = 15
) (
	input  logic [sca_pkg::ADDR_W-1:0] addr,
	input  logic [REM_W-1:0]           rem,
	input  logic [sca_pkg::SIZE_W-1:0] bsize,
	output logic [sca_pkg::ADDR_W-1:0] addr_next,
	output logic [REM_W-1:0]           rem_next,
	output logic                       more
);
	import sca_pkg::*;

	logic [REM_W-1:0] bsize_ext;

	// Widen block size to the remainder width
	assign bsize_ext = REM_W'(bsize);

	// Next block address wraps within the pool
	assign addr_next = addr + ADDR_W'(bsize);

	// Another block fits when the bytes left cover one more block
	assign more     = (rem >= bsize_ext);
	assign rem_next = rem - bsize_ext;

endmodule

### src/size_class_block_allocator.sv
// Top level of the size-class block allocator: sequencer, list heads and link memory.
//
//  channel | dir | handshake          | beat
//  --------+-----+--------------------+---------------------------------------------
//  in      | in  | in_valid/in_stall  | req_t: mode, request_size, block_address
//  out     | out | out_valid/out_stall| resp_t: granted_address, status
//
// A free or a rejected request skips S_POP_WAIT and S_CARVE. An allocate that
// carves a chunk links all CHUNK_BYTES / block size blocks of it in S_CARVE, one
// block a cycle through the single link memory write port. Reset clears all list
// heads, the chunk count and the pool base; the link memory is not cleared. A
// result waits in the output register while out_stall is high, and the next beat
// is taken meanwhile; a second result then waits its turn.
`timescale 1ns / 1ps
module size_class_block_allocator #(
	parameter int CHUNK_BYTES = sca_pkg::DEF_CHUNK_BYTES,
	parameter int CHUNK_LIMIT = sca_pkg::DEF_CHUNK_LIMIT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sca_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output sca_pkg::resp_t out_data
);
	import sca_pkg::*;

	localparam int REM_W = $clog2(CHUNK_BYTES + 1);
	localparam int CNT_W = $clog2(CHUNK_LIMIT + 1);

	state_t               state_q, state_d;
	req_t                 req_q;
	logic [CLASS_W-1:0]   cls_q;
	link_t                head_q [CLASS_COUNT];
	logic [CNT_W-1:0]     chunks_q;
	logic [ADDR_W-1:0]    base_q;
	logic [ADDR_W-1:0]    cur_q;
	logic [REM_W-1:0]     rem_q;
	logic                 first_q;
	logic [ADDR_W-1:0]    granted_q;
	status_t              status_q;
	logic                 out_valid_q;
	resp_t                out_data_q;

	logic [SIZE_W-1:0]    bsize;
	link_t                head_cur;
	logic                 size_zero;
	logic                 too_large;
	logic                 chunks_full;
	logic                 is_alloc;
	logic                 out_free;

	logic [ADDR_W-1:0]    step_addr_next;
	logic [REM_W-1:0]     step_rem_next;
	logic                 step_more;
	link_t                carve_link;

	logic                 ram_we;
	logic [LINK_IDX_W-1:0] ram_waddr;
	link_t                ram_wdata;
	logic [LINK_IDX_W-1:0] ram_raddr;
	logic [LINK_W-1:0]    ram_rdata;

	// Decode the held request
	assign bsize       = class_bytes(cls_q);
	assign head_cur    = head_q[cls_q];
	assign size_zero   = (req_q.request_size == '0);
	assign too_large   = (req_q.request_size > SIZE_W'(LARGEST_BLOCK));
	assign chunks_full = (chunks_q >= CNT_W'(CHUNK_LIMIT));
	assign is_alloc    = (req_q.mode == MODE_ALLOC);
	assign out_free    = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	sca_step_unit #(
		.REM_W(REM_W)
	) u_step (
		.addr      (cur_q),
		.rem       (rem_q),
		.bsize     (bsize),
		.addr_next (step_addr_next),
		.rem_next  (step_rem_next),
		.more      (step_more)
	);

	// Link of the block being carved: the next block, or end of list
	always_comb begin
		carve_link.valid = step_more;
		carve_link.addr  = step_more ? step_addr_next : '0;
	end

	sca_ram #(
		.WIDTH(LINK_W),
		.DEPTH(LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!size_zero && !too_large && is_alloc) begin
					if (head_cur.valid)
						state_d = S_POP_WAIT;
					else if (!chunks_full)
						state_d = S_CARVE;
					else
						state_d = S_RESP;
				end else begin
					state_d = S_RESP;
				end
			end
			S_POP_WAIT: state_d = S_RESP;
			S_CARVE: begin
				if (!step_more)
					state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Link memory controls; read always follows the current class head
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = req_q.block_address[BLOCK_LSB +: LINK_IDX_W];
		ram_wdata = head_cur;
		ram_raddr = head_cur.addr[BLOCK_LSB +: LINK_IDX_W];
		case (state_q)
			S_DECIDE: begin
				if (!size_zero && !too_large && !is_alloc)
					ram_we = 1'b1;
			end
			S_CARVE: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q[BLOCK_LSB +: LINK_IDX_W];
				ram_wdata = carve_link;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chunks_q    <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CLASS_COUNT; i++)
				head_q[i] <= '0;
		end else begin
			state_q <= state_d;
			// Raise the output beat on a new result, drop it once taken
			if (state_q == S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_DECIDE: begin
					if (!size_zero && !too_large) begin
						if (!is_alloc) begin
							head_q[cls_q] <= '{valid: 1'b1, addr: req_q.block_address};
						end else if (!head_cur.valid && !chunks_full) begin
							chunks_q <= chunks_q + CNT_W'(1);
							base_q   <= base_q + ADDR_W'(CHUNK_BYTES);
						end
					end
				end
				S_POP_WAIT: head_q[cls_q] <= link_t'(ram_rdata);
				S_CARVE: begin
					if (first_q)
						head_q[cls_q] <= carve_link;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= in_data;
				cls_q <= class_of(in_data.request_size);
			end
			S_DECIDE: begin
				if (size_zero) begin
					granted_q <= '0;
					status_q  <= ST_IGNORED;
				end else if (too_large) begin
					granted_q <= '0;
					status_q  <= is_alloc ? ST_TOO_LARGE : ST_IGNORED;
				end else if (!is_alloc) begin
					granted_q <= '0;
					status_q  <= ST_DONE;
				end else if (head_cur.valid) begin
					granted_q <= head_cur.addr;
					status_q  <= ST_DONE;
				end else if (chunks_full) begin
					granted_q <= '0;
					status_q  <= ST_NO_CHUNK;
				end else begin
					granted_q <= base_q;
					status_q  <= ST_DONE;
					cur_q     <= base_q;
					rem_q     <= REM_W'(CHUNK_BYTES) - REM_W'(bsize);
					first_q   <= 1'b1;
				end
			end
			S_CARVE: begin
				first_q <= 1'b0;
				cur_q   <= step_addr_next;
				rem_q   <= step_rem_next;
			end
			S_RESP: begin
				if (out_free)
					out_data_q <= '{granted_address: granted_q, status: status_q};
			end
			default: ;
		endcase
	end

endmodule
